// File: sv/ptm_pkg.sv
// shared types and codes for the pair table match and update unit
`default_nettype none

package ptm_pkg;

  // operation codes carried in the low bits of an input transaction
  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_CHANGE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // fixed field widths
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned COUNT_W = 5;

  // compare unit result handed to the sequencer
  typedef struct packed {
    logic id_hit;
    logic phone_hit;
  } cmp_t;

endpackage

`default_nettype wire

// File: sv/pair_table_match_update.sv
// top level: pair table with find, append and change over a scanned ram
`default_nettype none

// Pair table match and update unit. Holds up to TABLE_DEPTH (id, phone)
// pairs in two rams and runs one operation per input transaction, one at a
// time. Append and the unused op code go from acceptance straight to the
// finish step. Find and change read the table one entry after another
// through a single compare unit, each entry in a ram read step and then a
// compare step that writes back on a change; a find stops at its first
// hit. The input is not ready until the result has been loaded into the
// output register; a waiting result stalls only the next operation's
// completion. No clearing pass is needed after reset.
module pair_table_match_update_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // op[1:0], id_value[33:2], phone_value[65:34], new_id[97:66],
  // new_phone[129:98], zero fill[135:130]
  input  wire logic [135:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // status[1:0], match_index[5:2], entry_count[10:6], zero fill[15:11]
  output logic      [15:0]  m_tdata
);

  localparam int unsigned AddrW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CountW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxXW  = (AddrW > ptm_pkg::INDEX_W) ? AddrW : ptm_pkg::INDEX_W;
  localparam int unsigned CntXW  = (CountW > ptm_pkg::COUNT_W) ? CountW : ptm_pkg::COUNT_W;
  localparam int unsigned KW     = ptm_pkg::KEY_W;

  typedef enum logic [1:0] {
    IDLE,
    READ,
    CHECK,
    FINISH
  } state_t;

  state_t              state;
  logic [CountW-1:0]   count;
  logic [AddrW-1:0]    idx;
  logic [AddrW-1:0]    hit_index;
  logic [1:0]          op;
  logic [1:0]          status;
  logic [KW-1:0]       key_id;
  logic [KW-1:0]       key_phone;
  logic [KW-1:0]       rep_id;
  logic [KW-1:0]       rep_phone;

  // input transaction fields
  logic [1:0]          in_op;
  logic [KW-1:0]       in_id;
  logic [KW-1:0]       in_phone;
  logic [KW-1:0]       in_new_id;
  logic [KW-1:0]       in_new_phone;

  assign in_op        = s_tdata[1:0];
  assign in_id        = s_tdata[33:2];
  assign in_phone     = s_tdata[65:34];
  assign in_new_id    = s_tdata[97:66];
  assign in_new_phone = s_tdata[129:98];

  logic                accept;
  logic                full;
  logic                last_entry;
  logic                append_write;
  logic                change_step;
  logic [KW-1:0]       rd_id;
  logic [KW-1:0]       rd_phone;
  ptm_pkg::cmp_t       hit;
  logic                id_we;
  logic                phone_we;
  logic [AddrW-1:0]    waddr;
  logic [KW-1:0]       id_wdata;
  logic [KW-1:0]       phone_wdata;
  logic [IdxXW-1:0]    index_wide;
  logic [CntXW-1:0]    count_wide;

  assign s_tready   = (state == IDLE);
  assign accept     = s_tvalid && s_tready;
  assign full       = (count >= CountW'(TABLE_DEPTH));
  assign last_entry = ((CountW'(idx) + CountW'(1)) == count);

  // write port: append at acceptance, write back during a change scan
  assign append_write = accept && (in_op == ptm_pkg::OP_APPEND) && !full;
  assign change_step  = (state == CHECK) && (op == ptm_pkg::OP_CHANGE);
  assign id_we        = append_write || (change_step && hit.id_hit);
  assign phone_we     = append_write || (change_step && hit.phone_hit);
  assign waddr        = (state == CHECK) ? idx : count[AddrW-1:0];
  assign id_wdata     = (state == CHECK) ? rep_id : in_id;
  assign phone_wdata  = (state == CHECK) ? rep_phone : in_phone;

  ptm_ram #(
    .WIDTH (KW),
    .DEPTH (TABLE_DEPTH)
  ) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (waddr),
    .wdata (id_wdata),
    .raddr (idx),
    .rdata (rd_id)
  );

  ptm_ram #(
    .WIDTH (KW),
    .DEPTH (TABLE_DEPTH)
  ) u_phone_ram (
    .clk   (clk),
    .we    (phone_we),
    .waddr (waddr),
    .wdata (phone_wdata),
    .raddr (idx),
    .rdata (rd_phone)
  );

  ptm_cmp u_cmp (
    .entry_id    (rd_id),
    .entry_phone (rd_phone),
    .key_id      (key_id),
    .key_phone   (key_phone),
    .result      (hit)
  );

  // widen before trimming to the fixed result fields
  assign index_wide = IdxXW'(hit_index);
  assign count_wide = CntXW'(count);

  // sequencer with the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // finish step reloads the output register itself
      if (m_tvalid && m_tready && (state != FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            op        <= in_op;
            key_id    <= in_id;
            key_phone <= in_phone;
            rep_id    <= in_new_id;
            rep_phone <= in_new_phone;
            idx       <= '0;
            hit_index <= '0;
            unique case (in_op)
              ptm_pkg::OP_FIND: begin
                if (count == '0) begin
                  status <= ptm_pkg::ST_NOT_FOUND;
                  state  <= FINISH;
                end else begin
                  status <= ptm_pkg::ST_OK;
                  state  <= READ;
                end
              end
              ptm_pkg::OP_APPEND: begin
                if (full) begin
                  status <= ptm_pkg::ST_FULL;
                end else begin
                  status <= ptm_pkg::ST_OK;
                  count  <= count + CountW'(1);
                end
                state <= FINISH;
              end
              ptm_pkg::OP_CHANGE: begin
                status <= ptm_pkg::ST_OK;
                state  <= (count == '0) ? FINISH : READ;
              end
              default: begin
                status <= ptm_pkg::ST_OK;
                state  <= FINISH;
              end
            endcase
          end
        end
        READ: begin
          state <= CHECK;
        end
        CHECK: begin
          if (op == ptm_pkg::OP_FIND) begin
            if (hit.id_hit && hit.phone_hit) begin
              hit_index <= idx;
              state     <= FINISH;
            end else if (last_entry) begin
              status <= ptm_pkg::ST_NOT_FOUND;
              state  <= FINISH;
            end else begin
              idx   <= idx + AddrW'(1);
              state <= READ;
            end
          end else if (last_entry) begin
            state <= FINISH;
          end else begin
            idx   <= idx + AddrW'(1);
            state <= READ;
          end
        end
        FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, count_wide[ptm_pkg::COUNT_W-1:0],
                         index_wide[ptm_pkg::INDEX_W-1:0], status};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // the fill count never passes the table depth
  assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // an append into a table with room grows the count by exactly one
  assert property (@(posedge clk) disable iff (rst)
    (accept && (in_op == ptm_pkg::OP_APPEND) && !full)
      |=> (count == CountW'($past(count) + CountW'(1))))
    else $error("append did not grow the count by one");

  // the scan only reads entries below the count
  assert property (@(posedge clk) disable iff (rst)
    (state == READ) |-> (CountW'(idx) < count))
    else $error("scan index beyond the valid entries");

  // the unit is busy in the cycle after it takes an operation
  assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second operation taken while the first runs");

  // a result is only loaded from the finish step
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> ($past(state) == FINISH))
    else $error("result appeared outside the finish step");
`endif

endmodule

`default_nettype wire

// File: sv/ptm_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module ptm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AddrW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [AddrW-1:0]         raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/ptm_cmp.sv
// shared compare unit: checks one stored entry against the search keys
`default_nettype none

module ptm_cmp (
  input  wire logic [ptm_pkg::KEY_W-1:0] entry_id,
  input  wire logic [ptm_pkg::KEY_W-1:0] entry_phone,
  input  wire logic [ptm_pkg::KEY_W-1:0] key_id,
  input  wire logic [ptm_pkg::KEY_W-1:0] key_phone,
  output ptm_pkg::cmp_t                  result
);

  // two independent equality tests on the entry as read
  always_comb begin
    result.id_hit    = (entry_id == key_id);
    result.phone_hit = (entry_phone == key_phone);
  end

endmodule

`default_nettype wire

// File: bench/pair_table_match_update_unit_test.sv
// testbench for the pair table match and update unit with a built-in pair table tracker
`timescale 1ns / 1ps

module pair_table_match_update_unit_test;

  localparam int TABLE_DEPTH = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1580;
  localparam int HOLD_CYCLES = 400;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // expected fields of one result transaction
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] match_index;
    logic [4:0] entry_count;
  } pair_reply_t;

  // shadow copy of the pair table plus the replies it predicts
  class pair_table_tracker;
    logic [31:0] id_tab [TABLE_DEPTH];
    logic [31:0] phone_tab [TABLE_DEPTH];
    int fill;
    int errors;
    pair_reply_t pending_replies[$];

    function new();
      fill = 0;
      errors = 0;
    endfunction

    // apply one accepted operation to the shadow table and queue its reply
    function void note_request(logic [1:0] op, logic [31:0] id_v, logic [31:0] phone_v,
                               logic [31:0] id_new, logic [31:0] phone_new);
      pair_reply_t r;
      bit hit;
      r.status = ptm_pkg::ST_OK;
      r.match_index = '0;
      hit = 1'b0;
      case (op)
        ptm_pkg::OP_FIND: begin
          for (int i = 0; i < fill && !hit; i++) begin
            if (id_tab[i] == id_v && phone_tab[i] == phone_v) begin
              hit = 1'b1;
              r.match_index = i[3:0];
            end
          end
          if (!hit) r.status = ptm_pkg::ST_NOT_FOUND;
        end
        ptm_pkg::OP_APPEND: begin
          if (fill >= TABLE_DEPTH) begin
            r.status = ptm_pkg::ST_FULL;
          end else begin
            id_tab[fill] = id_v;
            phone_tab[fill] = phone_v;
            fill++;
          end
        end
        ptm_pkg::OP_CHANGE: begin
          // both tests look at the entry as it was before this pass
          for (int i = 0; i < fill; i++) begin
            if (id_tab[i] == id_v) id_tab[i] = id_new;
            if (phone_tab[i] == phone_v) phone_tab[i] = phone_new;
          end
        end
        default: ;
      endcase
      r.entry_count = fill[4:0];
      pending_replies.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare one accepted result against the oldest prediction
    task check_reply(logic [15:0] word);
      pair_reply_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("result %h with nothing pending", word));
        return;
      end
      want = pending_replies.pop_front();
      if (word[1:0] !== want.status)
        report($sformatf("status %0d, want %0d", word[1:0], want.status));
      if (word[5:2] !== want.match_index)
        report($sformatf("match_index %0d, want %0d", word[5:2], want.match_index));
      if (word[10:6] !== want.entry_count)
        report($sformatf("entry_count %0d, want %0d", word[10:6], want.entry_count));
      if (word[15:11] !== 5'd0)
        report($sformatf("fill bits %b not zero", word[15:11]));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [135:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;

  pair_table_tracker tracker = new();
  int burst_left = 0;
  int holds_requested = 0;
  int cycle_count = 0;

  pair_table_match_update_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // monitor both sides at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.check_reply(m_tdata);
      if (s_tvalid && s_tready)
        tracker.note_request(s_tdata[1:0], s_tdata[33:2], s_tdata[65:34],
                             s_tdata[97:66], s_tdata[129:98]);
    end
  end

  // receiver: changing stall patterns plus long hold-offs on request
  initial begin
    int left;
    int mode;
    int served;
    left = 0;
    mode = 0;
    served = 0;
    forever begin
      @(negedge clk);
      if (served < holds_requested) begin
        served++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 200);
        end
        left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((left % 8) < 5);
        endcase
      end
    end
  end

  // offer one transaction, wait for acceptance, then maybe leave a gap
  task automatic offer(input logic [1:0] op, input logic [31:0] id_v, input logic [31:0] phone_v,
                       input logic [31:0] id_new, input logic [31:0] phone_new);
    int gap;
    s_tdata <= {6'd0, phone_new, id_new, phone_v, id_v, op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(0, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // value likely to collide with something already stored
  function automatic logic [31:0] some_value();
    int n;
    int r;
    n = tracker.fill;
    r = $urandom_range(0, 9);
    if (r < 3 && n > 0) return tracker.id_tab[$urandom_range(0, n - 1)];
    if (r < 5 && n > 0) return tracker.phone_tab[$urandom_range(0, n - 1)];
    if (r < 7) begin
      case ($urandom_range(0, 3))
        0: return 32'd0;
        1: return 32'd1;
        2: return ALL_ONES;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  // random operation, mostly finds and changes aimed at stored pairs
  task automatic make_random(output logic [1:0] op, output logic [31:0] id_v,
                             output logic [31:0] phone_v, output logic [31:0] id_new,
                             output logic [31:0] phone_new);
    int r;
    int k;
    r = $urandom_range(0, 99);
    id_new = some_value();
    phone_new = some_value();
    if (r < 2) begin
      op = ptm_pkg::OP_APPEND;
      id_v = some_value();
      phone_v = some_value();
    end else if (r < 4) begin
      op = OP_UNUSED;
      id_v = $urandom;
      phone_v = $urandom;
    end else begin
      op = (r < 52) ? ptm_pkg::OP_FIND : ptm_pkg::OP_CHANGE;
      if (tracker.fill > 0 && $urandom_range(0, 1) == 1) begin
        k = $urandom_range(0, tracker.fill - 1);
        id_v = tracker.id_tab[k];
        phone_v = tracker.phone_tab[k];
      end else begin
        id_v = some_value();
        phone_v = some_value();
      end
    end
  endtask

  // main sequence
  initial begin
    logic [1:0] op;
    logic [31:0] id_v;
    logic [31:0] phone_v;
    logic [31:0] id_new;
    logic [31:0] phone_new;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table: find misses, change and unused code do nothing
    offer(ptm_pkg::OP_FIND, 32'd0, 32'd0, 32'd0, 32'd0);
    offer(ptm_pkg::OP_CHANGE, 32'd0, 32'd0, ALL_ONES, ALL_ONES);
    offer(OP_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    // extremes, with a duplicate of entry zero at the end
    offer(ptm_pkg::OP_APPEND, 32'd0, 32'd0, ALL_ONES, ALL_ONES);
    offer(ptm_pkg::OP_APPEND, ALL_ONES, ALL_ONES, 32'd0, 32'd0);
    offer(ptm_pkg::OP_APPEND, ALL_ONES, 32'd0, 32'd0, 32'd0);
    offer(ptm_pkg::OP_APPEND, 32'd0, 32'd0, 32'd0, 32'd0);
    // first match wins, both halves must match
    offer(ptm_pkg::OP_FIND, 32'd0, 32'd0, 32'd0, 32'd0);
    offer(ptm_pkg::OP_FIND, ALL_ONES, 32'd0, 32'd0, 32'd0);
    offer(ptm_pkg::OP_FIND, ALL_ONES, ALL_ONES, 32'd0, 32'd0);
    offer(ptm_pkg::OP_FIND, 32'd0, ALL_ONES, 32'd0, 32'd0);
    // independent id and phone rewrites from old values
    offer(ptm_pkg::OP_CHANGE, ALL_ONES, 32'd0, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    offer(ptm_pkg::OP_FIND, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'd0, 32'd0);
    offer(ptm_pkg::OP_CHANGE, 32'h5A5A_5A5A, ALL_ONES, 32'h5A5A_5A5A, 32'd0);
    offer(ptm_pkg::OP_CHANGE, 32'h1234_5678, 32'h9ABC_DEF0, ALL_ONES, ALL_ONES);
    offer(OP_UNUSED, 32'd0, 32'd0, 32'd0, 32'd0);
    offer(ptm_pkg::OP_FIND, 32'd0, 32'hA5A5_A5A5, 32'd0, 32'd0);

    // random part with a long receiver hold-off at the start and midway
    holds_requested = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) holds_requested = 2;
      make_random(op, id_v, phone_v, id_new, phone_new);
      offer(op, id_v, phone_v, id_new, phone_new);
    end
    s_tvalid <= 1'b0;

    // drain and let any trailing work settle
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ptm_pkg.sv
sv/ptm_ram.sv
sv/ptm_cmp.sv
sv/pair_table_match_update.sv
bench/pair_table_match_update_unit_test.sv
